// File: hw/rtl/mtrs_pkg.sv
package mtrs_pkg;

  // field widths of the request and result
  localparam int OPCODE_W     = 2;
  localparam int WINDOW_W     = 4;
  localparam int BITMAP_W     = 64;
  localparam int FIRST_TILE_W = 10;
  localparam int TILE_COUNT_W = 7;
  localparam int FCN_W        = 6;
  localparam int NEXT_STEP_W  = 2;

  // register widths
  localparam int ACK_MODE_W   = 2;
  localparam int WSIZE_W      = 7;
  localparam int WCOUNT_W     = 5;
  localparam int FTC_W        = 11;
  localparam int TILE_BYTES_W = 8;
  localparam int MTU_W        = 11;
  localparam int TPF_W        = 11;

  // one bitmap slot per window number
  localparam int BM_SLOTS = 16;

  // register port
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_ACK_MODE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_SIZE  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_WINDOW_COUNT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FULL_TILES   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_TILE_BYTES   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_LINK_MTU     = 3'd5;

  // register reset values
  localparam int ACK_MODE_RST     = 0;
  localparam int WINDOW_SIZE_RST  = 7;
  localparam int WINDOW_COUNT_RST = 1;
  localparam int FULL_TILES_RST   = 0;
  localparam int TILE_BYTES_RST   = 1;
  localparam int LINK_MTU_RST     = 51;
  localparam int TPF_RST          = (LINK_MTU_RST - 1) / TILE_BYTES_RST;

  // opcodes
  localparam logic [OPCODE_W-1:0] OP_WRITE_BITMAP = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_QUEUE_WINDOW = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_RESEND       = 2'd2;

  // ack modes
  localparam logic [ACK_MODE_W-1:0] ACK_PER_WINDOW  = 2'd0;
  localparam logic [ACK_MODE_W-1:0] ACK_SESSION_END = 2'd1;
  localparam logic [ACK_MODE_W-1:0] ACK_MULTI_WIN   = 2'd2;

  // follow-up codes
  localparam logic [NEXT_STEP_W-1:0] NEXT_NONE  = 2'd0;
  localparam logic [NEXT_STEP_W-1:0] NEXT_AGAIN = 2'd1;
  localparam logic [NEXT_STEP_W-1:0] NEXT_WAIT  = 2'd2;

endpackage

// File: hw/rtl/mtrs_div.sv
module mtrs_div import mtrs_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [MTU_W-1:0]        dividend,
  input  logic [TILE_BYTES_W-1:0] divisor,
  output logic                    busy,
  output logic                    done,
  output logic [TPF_W-1:0]        quotient
);

  localparam int CNT_W = $clog2(MTU_W + 1);

  logic [MTU_W-1:0]        quo;
  logic [TILE_BYTES_W-1:0] rem;
  logic [TILE_BYTES_W-1:0] dvs;
  logic [CNT_W-1:0]        cnt;
  logic [TILE_BYTES_W:0]   rem_sh;
  logic [TILE_BYTES_W:0]   rem_sub;
  logic                    fits;

  // restoring division, one quotient bit a cycle
  always_comb begin
    rem_sh  = {rem, quo[MTU_W-1]};
    fits    = rem_sh >= {1'b0, dvs};
    rem_sub = rem_sh - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= CNT_W'(MTU_W);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? rem_sub[TILE_BYTES_W-1:0] : rem_sh[TILE_BYTES_W-1:0];
        quo <= {quo[MTU_W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = TPF_W'(quo);

endmodule

// File: hw/rtl/missing_tile_resend_selector_core.sv
// channel   | handshake                 | payload
// ----------+---------------------------+----------------------------------------------
// request   | in_valid / in_stall       | opcode, window, current_window, bitmap_word
// result    | out_valid / out_stall     | frag_send .. ack_req_pending, one per request
// registers | psel penable pwrite pready| paddr (register i at 4*i), pwdata, prdata
//
// a resend request steps through the bitmap read, the scan states scan1 and scan2, a finish
// state that writes the bitmap back, and the idle state that takes the next request; the
// single bitmap memory port and the read-modify-write of one entry call for these steps
// bitmap writes, queue requests and ignored codes go from idle straight to finish
// after any write to a known register the tiles-per-fragment divider runs, with
// requests stalled
// rst is synchronous; it clears the queue, the served window and the ack-request flag;
// bitmaps hold no value until written
// a result waiting under out_stall holds the finish cycle; requests are still taken
// while an earlier result sits in the output register
module missing_tile_resend_selector_core import mtrs_pkg::*; #(
  parameter int MAX_WINDOW_SIZE = 64,
  parameter int MAX_WINDOWS     = 16
) (
  input  logic                    clk,
  input  logic                    rst,

  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OPCODE_W-1:0]     opcode,
  input  logic [WINDOW_W-1:0]     window,
  input  logic [WINDOW_W-1:0]     current_window,
  input  logic [BITMAP_W-1:0]     bitmap_word,

  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    frag_send,
  output logic [WINDOW_W-1:0]     frag_window,
  output logic [FIRST_TILE_W-1:0] first_tile,
  output logic [TILE_COUNT_W-1:0] tile_count,
  output logic [FCN_W-1:0]        fcn_value,
  output logic                    all1_send,
  output logic                    ack_req_send,
  output logic [NEXT_STEP_W-1:0]  next_step,
  output logic                    ack_req_pending,

  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_W-1:0]      paddr,
  input  logic [PDATA_W-1:0]      pwdata,
  output logic [PDATA_W-1:0]      prdata,
  output logic                    pready
);

  // bitmap width, tile-length and tile-index widths
  localparam int BW   = MAX_WINDOW_SIZE;
  localparam int LENW = $clog2(BW + 1);
  localparam int IW   = (BW > 1) ? $clog2(BW) : 1;
  // error queue pointers and fill count
  localparam int QAW  = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
  localparam int QCW  = $clog2(MAX_WINDOWS + 1);
  localparam logic [QAW-1:0] QLAST = QAW'(MAX_WINDOWS - 1);
  // window length arithmetic and first-tile sum
  localparam int PW   = FTC_W + LENW;
  localparam int FTW  = WINDOW_W + LENW + 1;
  localparam int BMAW = $clog2(BM_SLOTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADDR,
    S_SCAN1,
    S_SCAN2,
    S_FINISH
  } state_t;

  state_t state;

  // configuration registers
  logic [ACK_MODE_W-1:0]   ack_mode;
  logic [WSIZE_W-1:0]      window_size;
  logic [WCOUNT_W-1:0]     window_count;
  logic [FTC_W-1:0]        full_tile_count;
  logic [TILE_BYTES_W-1:0] tile_bytes;
  logic [MTU_W-1:0]        link_mtu_bytes;
  logic [TPF_W-1:0]        tiles_per_fragment;

  // divider control
  logic                    div_start;
  logic                    div_busy;
  logic                    div_done;
  logic [TPF_W-1:0]        div_quo;
  logic [MTU_W-1:0]        div_dividend;
  logic [TILE_BYTES_W-1:0] div_divisor;

  // register port decode
  logic                    cfg_we;
  logic [REG_IDX_W-1:0]    cfg_idx;
  logic                    cfg_known;

  // error queue
  logic [WINDOW_W-1:0]     q_mem [MAX_WINDOWS];
  logic [WINDOW_W-1:0]     q_rdata;
  logic [QAW-1:0]          q_head;
  logic [QAW-1:0]          q_tail;
  logic [QCW-1:0]          q_count;

  // bitmap memory
  logic [BW-1:0]           bm_mem [BM_SLOTS];
  logic [BW-1:0]           bm_rdata;
  logic [WINDOW_W-1:0]     bm_raddr;
  logic [WINDOW_W-1:0]     bm_waddr;
  logic [BW-1:0]           bm_wdata;
  logic                    bm_we;

  logic [WINDOW_W-1:0]     served_window;
  logic                    ack_req_flag;

  // request held while it is worked on
  logic [OPCODE_W-1:0]     op_q;
  logic [WINDOW_W-1:0]     win_q;
  logic [WINDOW_W-1:0]     cur_q;
  logic [BW-1:0]           word_q;

  // address stage results
  logic [WINDOW_W-1:0]     sel_q;
  logic [LENW-1:0]         len_q;
  logic                    last_q;
  logic                    flag_path_q;

  // scan stage results
  logic [BW-1:0]           bm_q;
  logic [BW-1:0]           lenmask_q;
  logic [BW-1:0]           low_q;
  logic [BW-1:0]           runmask_q;
  logic [BW:0]             endhot_q;
  logic                    all1_q;
  logic [LENW-1:0]         n_q;
  logic [FTW-1:0]          ft_q;
  logic [FCN_W-1:0]        fcn_q;

  // combinational helpers
  logic                    mode_ok;
  logic                    compound;
  logic [LENW-1:0]         ws_eff;
  logic [WINDOW_W-1:0]     sel_win;
  logic                    flag_path;
  logic                    sel_last;
  logic [PW-1:0]           base;
  logic [PW-1:0]           ftc_x;
  logic [PW-1:0]           tail_diff;
  logic [LENW-1:0]         tail_len;
  logic [LENW-1:0]         win_len;

  logic [BW-1:0]           lenmask;
  logic [BW-1:0]           zeros;
  logic [BW-1:0]           low;
  logic [BW:0]             carry_sum;
  logic [IW-1:0]           ws_idx;

  logic [IW-1:0]           start_idx;
  logic [LENW-1:0]         run_len;
  logic [LENW-1:0]         n_clamped;
  logic [FTW-1:0]          ft_sum;
  logic [7:0]              fcn_diff;

  logic [BW:0]             span;
  logic [BW-1:0]           new_bm;
  logic                    complete;
  logic                    out_free;
  logic                    finishing;
  logic                    resend_op;
  logic                    ack_path;
  logic                    resend;
  logic                    frag;
  logic                    push;
  logic                    pop;
  logic                    flag_next;
  logic [NEXT_STEP_W-1:0]  next_val;

  // index of the single set bit of a one-hot vector
  function automatic logic [LENW-1:0] onehot_idx(input logic [BW:0] v);
    logic [LENW-1:0] r;
    r = '0;
    for (int i = 0; i <= BW; i++) begin
      if (v[i]) r = r | LENW'(i);
    end
    return r;
  endfunction

  function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
    return (p == QLAST) ? '0 : p + QAW'(1);
  endfunction

  // ------------------------------------------------------------------
  // register port
  // ------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_idx   = paddr[PADDR_W-1:2];
  assign cfg_we    = psel && penable && pwrite;
  assign cfg_known = (cfg_idx == REG_ACK_MODE) || (cfg_idx == REG_WINDOW_SIZE) ||
                     (cfg_idx == REG_WINDOW_COUNT) || (cfg_idx == REG_FULL_TILES) ||
                     (cfg_idx == REG_TILE_BYTES) || (cfg_idx == REG_LINK_MTU);

  always_ff @(posedge clk) begin
    if (rst) begin
      ack_mode           <= ACK_MODE_W'(ACK_MODE_RST);
      window_size        <= WSIZE_W'(WINDOW_SIZE_RST);
      window_count       <= WCOUNT_W'(WINDOW_COUNT_RST);
      full_tile_count    <= FTC_W'(FULL_TILES_RST);
      tile_bytes         <= TILE_BYTES_W'(TILE_BYTES_RST);
      link_mtu_bytes     <= MTU_W'(LINK_MTU_RST);
      tiles_per_fragment <= TPF_W'(TPF_RST);
      div_start          <= 1'b0;
    end else begin
      // recompute tiles per fragment the cycle after any write to a known register
      div_start <= cfg_we && cfg_known;
      if (div_done) begin
        tiles_per_fragment <= div_quo;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_ACK_MODE:     ack_mode        <= pwdata[ACK_MODE_W-1:0];
          REG_WINDOW_SIZE:  window_size     <= pwdata[WSIZE_W-1:0];
          REG_WINDOW_COUNT: window_count    <= pwdata[WCOUNT_W-1:0];
          REG_FULL_TILES:   full_tile_count <= pwdata[FTC_W-1:0];
          REG_TILE_BYTES:   tile_bytes      <= pwdata[TILE_BYTES_W-1:0];
          REG_LINK_MTU:     link_mtu_bytes  <= pwdata[MTU_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ACK_MODE:     prdata = PDATA_W'(ack_mode);
      REG_WINDOW_SIZE:  prdata = PDATA_W'(window_size);
      REG_WINDOW_COUNT: prdata = PDATA_W'(window_count);
      REG_FULL_TILES:   prdata = PDATA_W'(full_tile_count);
      REG_TILE_BYTES:   prdata = PDATA_W'(tile_bytes);
      REG_LINK_MTU:     prdata = PDATA_W'(link_mtu_bytes);
      default:          prdata = '0;
    endcase
  end

  // zero-byte tiles count as one byte; an mtu of zero fits no tile
  assign div_dividend = (link_mtu_bytes != '0) ? link_mtu_bytes - MTU_W'(1) : '0;
  assign div_divisor  = (tile_bytes != '0) ? tile_bytes : TILE_BYTES_W'(1);

  mtrs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ------------------------------------------------------------------
  // memories
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (push && finishing) begin
      q_mem[q_tail] <= win_q;
    end
    // head entry always read; settled the cycle after the head moves
    q_rdata <= q_mem[q_head];
  end

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_waddr[BMAW-1:0]] <= bm_wdata;
    end
    if (state == S_ADDR) begin
      bm_rdata <= bm_mem[bm_raddr[BMAW-1:0]];
    end
  end

  // ------------------------------------------------------------------
  // address stage: pick the window, its length and the bitmap to read
  // ------------------------------------------------------------------
  assign mode_ok  = (ack_mode == ACK_PER_WINDOW) || (ack_mode == ACK_SESSION_END) ||
                    (ack_mode == ACK_MULTI_WIN);
  assign compound = (ack_mode == ACK_MULTI_WIN);
  assign ws_eff   = (window_size > WSIZE_W'(BW)) ? LENW'(BW) : LENW'(window_size);

  always_comb begin
    // compound mode serves the queue head, or keeps the last served window
    if (compound) begin
      sel_win = (q_count != '0) ? q_rdata : served_window;
    end else begin
      sel_win = win_q;
    end
    flag_path = compound && ack_req_flag;
    bm_raddr  = flag_path ? cur_q : sel_win;

    // the last window is shortened to what the full-tile total leaves
    sel_last  = (window_count != '0) && (WCOUNT_W'(sel_win) == window_count - WCOUNT_W'(1));
    base      = PW'(window_count - WCOUNT_W'(1)) * PW'(ws_eff);
    ftc_x     = PW'(full_tile_count);
    tail_diff = ftc_x - base;
    if (ftc_x <= base) begin
      tail_len = '0;
    end else if (tail_diff > PW'(ws_eff)) begin
      tail_len = ws_eff;
    end else begin
      tail_len = LENW'(tail_diff);
    end
    win_len = sel_last ? tail_len : ws_eff;
  end

  // ------------------------------------------------------------------
  // scan stage one: missing tiles, first of them, and the run that follows
  // ------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < BW; i++) begin
      lenmask[i] = (len_q > LENW'(i));
    end
    zeros     = ~bm_rdata & lenmask;
    low       = zeros & (~zeros + BW'(1));
    // adding the lowest missing bit carries through the run and stops past it
    carry_sum = {1'b0, zeros} + {1'b0, low};
    ws_idx    = IW'(ws_eff - LENW'(1));
  end

  // ------------------------------------------------------------------
  // scan stage two: run start, length clamped to the fragment size
  // ------------------------------------------------------------------
  always_comb begin
    start_idx = IW'(onehot_idx({1'b0, low_q}));
    run_len   = onehot_idx(endhot_q) - LENW'(start_idx);
    n_clamped = (TPF_W'(run_len) > tiles_per_fragment) ? LENW'(tiles_per_fragment) : run_len;
    ft_sum    = FTW'(sel_q) * FTW'(ws_eff) + FTW'(start_idx);
    fcn_diff  = 8'(ws_eff) - 8'(start_idx) - 8'd1;
  end

  // ------------------------------------------------------------------
  // finish: mark sent tiles, follow-up, queue and flag
  // ------------------------------------------------------------------
  always_comb begin
    out_free  = !out_valid || !out_stall;
    finishing = (state == S_FINISH) && out_free;

    span      = ({1'b0, low_q} << n_q) - (BW + 1)'(1);
    new_bm    = bm_q | (span[BW-1:0] & runmask_q);
    complete  = &(new_bm | ~lenmask_q);

    resend_op = (op_q == OP_RESEND) && mode_ok;
    ack_path  = resend_op && compound && flag_path_q;
    resend    = resend_op && !ack_path;
    frag      = resend && (n_q != '0);

    push      = (op_q == OP_QUEUE_WINDOW) && (q_count < QCW'(MAX_WINDOWS));
    pop       = resend && compound && complete && (q_count != '0);

    flag_next = ack_req_flag;
    if (resend && (ack_mode == ACK_SESSION_END) && complete) begin
      flag_next = 1'b1;
    end
    if (resend && compound && complete && (q_count <= QCW'(1))) begin
      flag_next = 1'b1;
    end
    if (ack_path) begin
      flag_next = 1'b0;
    end

    next_val = NEXT_NONE;
    if (ack_path) begin
      next_val = NEXT_WAIT;
    end else if (resend && (ack_mode == ACK_PER_WINDOW)) begin
      if (!complete) begin
        next_val = NEXT_AGAIN;
      end else if (len_q != '0) begin
        next_val = NEXT_WAIT;
      end
    end

    bm_we    = finishing && ((op_q == OP_WRITE_BITMAP) || frag);
    bm_waddr = (op_q == OP_WRITE_BITMAP) ? win_q : sel_q;
    bm_wdata = (op_q == OP_WRITE_BITMAP) ? word_q : new_bm;
  end

  assign in_stall = (state != S_IDLE) || div_start || div_busy;

  // ------------------------------------------------------------------
  // sequencer and result register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      q_head        <= '0;
      q_tail        <= '0;
      q_count       <= '0;
      served_window <= '0;
      ack_req_flag  <= 1'b0;
    end else begin
      // result taken and no new one replacing it this cycle
      if (out_valid && !out_stall && !finishing) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            op_q   <= opcode;
            win_q  <= window;
            cur_q  <= current_window;
            word_q <= bitmap_word[BW-1:0];
            state  <= ((opcode == OP_RESEND) && mode_ok) ? S_ADDR : S_FINISH;
          end
        end
        S_ADDR: begin
          sel_q       <= sel_win;
          len_q       <= win_len;
          last_q      <= sel_last;
          flag_path_q <= flag_path;
          state       <= S_SCAN1;
        end
        S_SCAN1: begin
          bm_q      <= bm_rdata;
          lenmask_q <= lenmask;
          low_q     <= low;
          runmask_q <= zeros & ~carry_sum[BW-1:0];
          endhot_q  <= carry_sum & ~{1'b0, zeros};
          // all-1 needed when the last tile of the current window is missing
          all1_q    <= last_q && (ws_eff != '0) && !bm_rdata[ws_idx];
          state     <= S_SCAN2;
        end
        S_SCAN2: begin
          n_q     <= n_clamped;
          ft_q    <= ft_sum;
          fcn_q   <= FCN_W'(fcn_diff);
          state   <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            out_valid       <= 1'b1;
            frag_send       <= frag;
            frag_window     <= frag ? sel_q : (ack_path ? cur_q : '0);
            first_tile      <= frag ? FIRST_TILE_W'(ft_q) : '0;
            tile_count      <= frag ? TILE_COUNT_W'(n_q) : '0;
            fcn_value       <= frag ? fcn_q : '0;
            all1_send       <= ack_path && all1_q;
            ack_req_send    <= ack_path;
            next_step       <= next_val;
            ack_req_pending <= flag_next;
            ack_req_flag    <= flag_next;
            if (resend_op) begin
              served_window <= sel_q;
            end
            if (push) begin
              q_tail  <= ptr_inc(q_tail);
              q_count <= q_count + QCW'(1);
            end
            if (pop) begin
              q_head  <= ptr_inc(q_head);
              q_count <= q_count - QCW'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/mtrs_chk.sv
module mtrs_chk import mtrs_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic                    frag_send,
  input logic [WINDOW_W-1:0]     frag_window,
  input logic [FIRST_TILE_W-1:0] first_tile,
  input logic [TILE_COUNT_W-1:0] tile_count,
  input logic [FCN_W-1:0]        fcn_value,
  input logic                    all1_send,
  input logic                    ack_req_send,
  input logic [NEXT_STEP_W-1:0]  next_step,
  input logic                    ack_req_pending
);

  // a stalled result stays and holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frag_window) && $stable(first_tile) &&
      $stable(tile_count) && $stable(fcn_value) && $stable(next_step))
    else $error("result changed while stalled");

  // fragment fields are zero when no fragment goes out
  a_no_frag_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frag_send |-> first_tile == '0 && tile_count == '0 && fcn_value == '0)
    else $error("fragment fields set without a fragment");

  // a fragment carries tiles and never comes with an ack request
  a_frag_tiles: assert property (@(posedge clk) disable iff (rst)
    out_valid && frag_send |-> tile_count != '0 && !ack_req_send)
    else $error("empty fragment or fragment with ack request");

  // an ack request waits for the ack and clears the pending flag
  a_ack_req: assert property (@(posedge clk) disable iff (rst)
    out_valid && ack_req_send |-> next_step == NEXT_WAIT && !ack_req_pending)
    else $error("ack request with wrong follow-up");

  // all-1 only goes out ahead of an ack request
  a_all1: assert property (@(posedge clk) disable iff (rst)
    out_valid && all1_send |-> ack_req_send)
    else $error("all-1 without ack request");

endmodule

bind missing_tile_resend_selector_core mtrs_chk u_mtrs_chk (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .frag_send       (frag_send),
  .frag_window     (frag_window),
  .first_tile      (first_tile),
  .tile_count      (tile_count),
  .fcn_value       (fcn_value),
  .all1_send       (all1_send),
  .ack_req_send    (ack_req_send),
  .next_step       (next_step),
  .ack_req_pending (ack_req_pending)
);

// File: test/missing_tile_resend_selector_core_tb.sv
`timescale 1ns / 1ps

module missing_tile_resend_selector_core_tb;
  import mtrs_pkg::*;

  // codes the package leaves unnamed
  localparam logic [OPCODE_W-1:0]   OP_IGNORED  = 2'd3;
  localparam logic [ACK_MODE_W-1:0] ACK_IGNORED = 2'd3;

  localparam int ERRQ_DEPTH     = 16;
  localparam int ITEM_TARGET    = 1300;
  localparam int PHASE_ITEMS    = 80;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int N_FIXED        = 10;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [WINDOW_W-1:0] window;
    logic [WINDOW_W-1:0] current_window;
    logic [BITMAP_W-1:0] bitmap_word;
  } tile_request_t;

  typedef struct packed {
    logic                    frag_send;
    logic [WINDOW_W-1:0]     frag_window;
    logic [FIRST_TILE_W-1:0] first_tile;
    logic [TILE_COUNT_W-1:0] tile_count;
    logic [FCN_W-1:0]        fcn_value;
    logic                    all1_send;
    logic                    ack_req_send;
    logic [NEXT_STEP_W-1:0]  next_step;
    logic                    ack_req_pending;
  } resend_result_t;

  // predicts the selector's answer to every accepted request and checks the results
  class resend_scoreboard;
    logic [ACK_MODE_W-1:0]   ack_mode;
    logic [WSIZE_W-1:0]      window_size;
    logic [WCOUNT_W-1:0]     window_count;
    logic [FTC_W-1:0]        full_tiles;
    logic [TILE_BYTES_W-1:0] tile_bytes;
    logic [MTU_W-1:0]        link_mtu;
    int                      tiles_per_frag;
    logic [BITMAP_W-1:0]     rx_bitmap [BM_SLOTS];
    logic [WINDOW_W-1:0]     error_windows [ERRQ_DEPTH];
    int                      errq_head;
    int                      errq_count;
    logic [WINDOW_W-1:0]     served_window;
    bit                      ack_flag;
    resend_result_t          awaited_results [$];
    int                      errors;

    function new();
      ack_mode     = ACK_MODE_RST;
      window_size  = WINDOW_SIZE_RST;
      window_count = WINDOW_COUNT_RST;
      full_tiles   = FULL_TILES_RST;
      tile_bytes   = TILE_BYTES_RST;
      link_mtu     = LINK_MTU_RST;
      foreach (rx_bitmap[i]) rx_bitmap[i] = '0;
      foreach (error_windows[i]) error_windows[i] = '0;
      errq_head     = 0;
      errq_count    = 0;
      served_window = '0;
      ack_flag      = 1'b0;
      errors        = 0;
      derive_tpf();
    endfunction

    function void derive_tpf();
      int tb;
      tb = (tile_bytes == 0) ? 1 : int'(tile_bytes);
      tiles_per_frag = (link_mtu >= 1) ? (int'(link_mtu) - 1) / tb : 0;
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] val);
      case (idx)
        REG_ACK_MODE:     ack_mode     = val[ACK_MODE_W-1:0];
        REG_WINDOW_SIZE:  window_size  = val[WSIZE_W-1:0];
        REG_WINDOW_COUNT: window_count = val[WCOUNT_W-1:0];
        REG_FULL_TILES:   full_tiles   = val[FTC_W-1:0];
        REG_TILE_BYTES:   tile_bytes   = val[TILE_BYTES_W-1:0];
        REG_LINK_MTU:     link_mtu     = val[MTU_W-1:0];
        default: ;
      endcase
      derive_tpf();
    endfunction

    function logic [PDATA_W-1:0] reg_value(logic [REG_IDX_W-1:0] idx);
      case (idx)
        REG_ACK_MODE:     return PDATA_W'(ack_mode);
        REG_WINDOW_SIZE:  return PDATA_W'(window_size);
        REG_WINDOW_COUNT: return PDATA_W'(window_count);
        REG_FULL_TILES:   return PDATA_W'(full_tiles);
        REG_TILE_BYTES:   return PDATA_W'(tile_bytes);
        REG_LINK_MTU:     return PDATA_W'(link_mtu);
        default:          return '0;
      endcase
    endfunction

    function int eff_ws();
      return (window_size > 64) ? 64 : int'(window_size);
    endfunction

    function bit is_last(logic [WINDOW_W-1:0] w);
      return window_count != 0 && int'(w) == int'(window_count) - 1;
    endfunction

    // last window is clamped by the full tile count, every other one is full
    function int window_len(logic [WINDOW_W-1:0] w);
      int ws, len;
      ws = eff_ws();
      if (!is_last(w)) return ws;
      len = int'(full_tiles) - (int'(window_count) - 1) * ws;
      if (len < 0) len = 0;
      if (len > ws) len = ws;
      return len;
    endfunction

    function bit window_complete(logic [WINDOW_W-1:0] w, int len);
      for (int i = 0; i < len; i++)
        if (!rx_bitmap[w][i]) return 1'b0;
      return 1'b1;
    endfunction

    function bit window_done(logic [WINDOW_W-1:0] w);
      return window_complete(w, window_len(w));
    endfunction

    // first run of missing tiles, cut to what fits in one fragment, then marked sent
    function void resend_run(logic [WINDOW_W-1:0] w, int len, inout resend_result_t e);
      logic [BITMAP_W-1:0] bm, run_mask;
      int start, run, n, ws;
      bit found;
      bm    = rx_bitmap[w];
      start = 0;
      run   = 0;
      found = 1'b0;
      ws    = eff_ws();
      for (int i = 0; i < len; i++) begin
        if (!bm[i]) begin
          if (!found) begin
            found = 1'b1;
            start = i;
          end
          run++;
        end else if (found) break;
      end
      n = (run > tiles_per_frag) ? tiles_per_frag : run;
      if (n != 0) begin
        run_mask     = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
        rx_bitmap[w] = bm | (run_mask << start);
        e.frag_send   = 1'b1;
        e.frag_window = w;
        e.first_tile  = FIRST_TILE_W'(int'(w) * ws + start);
        e.tile_count  = TILE_COUNT_W'(n);
        e.fcn_value   = FCN_W'(ws - 1 - start);
      end
    endfunction

    function void note_request(tile_request_t r);
      resend_result_t e;
      int len;
      e = '0;
      case (r.opcode)
        OP_WRITE_BITMAP: rx_bitmap[r.window] = r.bitmap_word;
        OP_QUEUE_WINDOW: begin
          // a full queue drops the request
          if (errq_count < ERRQ_DEPTH) begin
            error_windows[(errq_head + errq_count) % ERRQ_DEPTH] = r.window;
            errq_count++;
          end
        end
        OP_RESEND: begin
          if (ack_mode == ACK_PER_WINDOW || ack_mode == ACK_SESSION_END) begin
            served_window = r.window;
            len = window_len(r.window);
            resend_run(r.window, len, e);
            if (ack_mode == ACK_PER_WINDOW) begin
              if (!window_complete(r.window, len)) e.next_step = NEXT_AGAIN;
              else if (len > 0) e.next_step = NEXT_WAIT;
            end else if (window_complete(r.window, len)) begin
              ack_flag = 1'b1;
            end
          end else if (ack_mode == ACK_MULTI_WIN) begin
            if (errq_count != 0) served_window = error_windows[errq_head];
            if (ack_flag) begin
              // ack request instead of a fragment, All-1 first when the tail is missing
              if (is_last(served_window) && eff_ws() != 0 &&
                  !rx_bitmap[r.current_window][eff_ws() - 1])
                e.all1_send = 1'b1;
              e.frag_window  = r.current_window;
              e.ack_req_send = 1'b1;
              e.next_step    = NEXT_WAIT;
              ack_flag       = 1'b0;
            end else begin
              len = window_len(served_window);
              resend_run(served_window, len, e);
              if (window_complete(served_window, len)) begin
                if (errq_count != 0) begin
                  errq_head = (errq_head + 1) % ERRQ_DEPTH;
                  errq_count--;
                end
                if (errq_count == 0) ack_flag = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      e.ack_req_pending = ack_flag;
      awaited_results.push_back(e);
    endfunction

    function void cmp(string what, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(resend_result_t got);
      resend_result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual %0h", $time, got);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      cmp("frag_send", want.frag_send, got.frag_send);
      cmp("frag_window", want.frag_window, got.frag_window);
      cmp("first_tile", want.first_tile, got.first_tile);
      cmp("tile_count", want.tile_count, got.tile_count);
      cmp("fcn_value", want.fcn_value, got.fcn_value);
      cmp("all1_send", want.all1_send, got.all1_send);
      cmp("ack_req_send", want.ack_req_send, got.ack_req_send);
      cmp("next_step", want.next_step, got.next_step);
      cmp("ack_req_pending", want.ack_req_pending, got.ack_req_pending);
    endfunction
  endclass

  logic                    clk            = 1'b0;
  logic                    rst            = 1'b1;
  logic                    in_valid       = 1'b0;
  logic                    in_stall;
  logic [OPCODE_W-1:0]     opcode         = '0;
  logic [WINDOW_W-1:0]     window         = '0;
  logic [WINDOW_W-1:0]     current_window = '0;
  logic [BITMAP_W-1:0]     bitmap_word    = '0;
  logic                    out_valid;
  logic                    out_stall      = 1'b0;
  logic                    frag_send;
  logic [WINDOW_W-1:0]     frag_window;
  logic [FIRST_TILE_W-1:0] first_tile;
  logic [TILE_COUNT_W-1:0] tile_count;
  logic [FCN_W-1:0]        fcn_value;
  logic                    all1_send;
  logic                    ack_req_send;
  logic [NEXT_STEP_W-1:0]  next_step;
  logic                    ack_req_pending;
  logic                    psel           = 1'b0;
  logic                    penable        = 1'b0;
  logic                    pwrite         = 1'b0;
  logic [PADDR_W-1:0]      paddr          = '0;
  logic [PDATA_W-1:0]      pwdata         = '0;
  logic [PDATA_W-1:0]      prdata;
  logic                    pready;

  resend_scoreboard sb = new();
  resend_result_t   seen;
  bit               quiet = 1'b0;   // phase without any idling on either side
  int               counted_items = 0;
  int               stall_hold = 0;
  int               idle_cycles = 0;

  // register settings walked through first: extremes, saturation and every ack mode
  int fixed_cfg [N_FIXED][6] = '{
    '{ACK_PER_WINDOW,   64, 16, 1024,   1, 1500},
    '{ACK_SESSION_END,   1,  1,    0, 255,    2},
    '{ACK_MULTI_WIN,     8,  4,   30,   2,    9},
    '{ACK_IGNORED,       7,  1,    0,   1,   51},
    '{ACK_MULTI_WIN,   127, 31, 2047,   0, 2047},
    '{ACK_PER_WINDOW,    0,  0,    0,   3,    0},
    '{ACK_SESSION_END,  16,  5,   70,   8,   33},
    '{ACK_MULTI_WIN,    64, 16, 1000, 255, 1500},
    '{ACK_PER_WINDOW,    5, 16,  100,   1,    4},
    '{ACK_MULTI_WIN,     3,  2,    4,   1,    1}
  };

  missing_tile_resend_selector_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .opcode         (opcode),
    .window         (window),
    .current_window (current_window),
    .bitmap_word    (bitmap_word),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frag_send      (frag_send),
    .frag_window    (frag_window),
    .first_tile     (first_tile),
    .tile_count     (tile_count),
    .fcn_value      (fcn_value),
    .all1_send      (all1_send),
    .ack_req_send   (ack_req_send),
    .next_step      (next_step),
    .ack_req_pending(ack_req_pending),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #4 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  // result side: check every accepted result, then decide the next stall
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      seen = '{frag_send, frag_window, first_tile, tile_count, fcn_value,
               all1_send, ack_req_send, next_step, ack_req_pending};
      sb.check_result(seen);
    end
    if (stall_hold > 0) begin
      stall_hold--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 99) < 30) begin
      stall_hold = pick_gap() - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog: too long without any transfer on any port means the block hangs
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one request, held until the block takes it; valid stays up when no gap follows
  task automatic send_request(logic [OPCODE_W-1:0] op, logic [WINDOW_W-1:0] w,
                              logic [WINDOW_W-1:0] cur, logic [BITMAP_W-1:0] bm);
    tile_request_t r;
    int gap;
    r = '{op, w, cur, bm};
    opcode         <= op;
    window         <= w;
    current_window <= cur;
    bitmap_word    <= bm;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_request(r);
    counted_items++;
    gap = (quiet || $urandom_range(0, 9) < 6) ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // lower valid and let every outstanding result come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // apb write, then read back the same register
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] val);
    logic [PDATA_W-1:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.cmp($sformatf("register %0d readback", idx), sb.reg_value(idx), rd);
  endtask

  task automatic apply_config(int ack, int ws, int wc, int ftc, int tb, int mtu);
    write_reg(REG_ACK_MODE, ack);
    write_reg(REG_WINDOW_SIZE, ws);
    write_reg(REG_WINDOW_COUNT, wc);
    write_reg(REG_FULL_TILES, ftc);
    write_reg(REG_TILE_BYTES, tb);
    write_reg(REG_LINK_MTU, mtu);
  endtask

  task automatic apply_random_config();
    int ack, ws, wc, ftc, tb, mtu;
    ack = ($urandom_range(0, 9) == 0) ? int'(ACK_IGNORED) : $urandom_range(0, 2);
    ws  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 64);
    wc  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
    ftc = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 1024);
    tb  = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 8) : $urandom_range(0, 255);
    mtu = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(2, 1500);
    apply_config(ack, ws, wc, ftc, tb, mtu);
  endtask

  // favor the last window of the session, it has the odd length and the All-1 check
  function automatic logic [WINDOW_W-1:0] pick_window();
    if (sb.window_count != 0 && sb.window_count <= BM_SLOTS && $urandom_range(0, 9) < 3)
      return WINDOW_W'(sb.window_count - 1);
    return WINDOW_W'($urandom_range(0, 15));
  endfunction

  // empty, full, random, a few holes, or one run of holes inside the window
  function automatic logic [BITMAP_W-1:0] rand_bitmap();
    logic [BITMAP_W-1:0] bm;
    int span, lo;
    span = (sb.eff_ws() == 0) ? 1 : sb.eff_ws();
    case ($urandom_range(0, 9))
      0: bm = '0;
      1: bm = '1;
      2, 3, 4: bm = {$urandom, $urandom};
      5, 6, 7: begin
        bm = '1;
        repeat ($urandom_range(1, 4)) bm[$urandom_range(0, span - 1)] = 1'b0;
      end
      default: begin
        lo = $urandom_range(0, span - 1);
        bm = ~(((64'd1 << $urandom_range(1, 8)) - 64'd1) << lo);
      end
    endcase
    return bm;
  endfunction

  // a whole exchange: fill bitmaps, then resend until the mode's natural stop
  task automatic well_formed();
    logic [WINDOW_W-1:0] w;
    int steps;
    steps = 0;
    if (sb.ack_mode == ACK_MULTI_WIN) begin
      repeat ($urandom_range(1, 3)) begin
        w = pick_window();
        send_request(OP_WRITE_BITMAP, w, WINDOW_W'($urandom), rand_bitmap());
        send_request(OP_QUEUE_WINDOW, w, WINDOW_W'($urandom), {$urandom, $urandom});
      end
      // resend until the queue drains and raises the flag, then one ack request step
      do begin
        send_request(OP_RESEND, WINDOW_W'($urandom), pick_window(), {$urandom, $urandom});
        steps++;
      end while (!sb.ack_flag && steps < 40);
      send_request(OP_RESEND, WINDOW_W'($urandom), pick_window(), {$urandom, $urandom});
    end else begin
      w = pick_window();
      send_request(OP_WRITE_BITMAP, w, WINDOW_W'($urandom), rand_bitmap());
      do begin
        send_request(OP_RESEND, w, pick_window(), {$urandom, $urandom});
        steps++;
      end while (!sb.window_done(w) && steps < 40);
    end
  endtask

  task automatic noise();
    repeat ($urandom_range(2, 6))
      send_request(OPCODE_W'($urandom), WINDOW_W'($urandom), WINDOW_W'($urandom),
                   rand_bitmap());
  endtask

  // at least as many queue requests as the queue holds
  task automatic flood_queue();
    repeat ($urandom_range(16, 20))
      send_request(OP_QUEUE_WINDOW, pick_window(), WINDOW_W'($urandom), {$urandom, $urandom});
  endtask

  task automatic run_phase(int n);
    int first, roll;
    first = counted_items;
    while (counted_items - first < n) begin
      roll = $urandom_range(0, 9);
      if (roll < 7) well_formed();
      else if (roll == 9 && sb.ack_mode == ACK_MULTI_WIN) flood_queue();
      else noise();
    end
  endtask

  // reset settings: mode per window, 7 tiles, window 0 is the last one and has no tiles
  task automatic run_directed();
    send_request(OP_WRITE_BITMAP, 4'd2, 4'd0, '0);
    send_request(OP_RESEND, 4'd2, 4'd0, '0);            // whole window missing
    send_request(OP_RESEND, 4'd0, 4'd15, '1);           // last window without tiles
    send_request(OP_WRITE_BITMAP, 4'd4, 4'd0, '1);
    send_request(OP_RESEND, 4'd4, 4'd0, '0);            // already complete
    send_request(OP_WRITE_BITMAP, 4'd6, 4'd0, 64'hFFFF_FFFF_FFFF_FFFA);
    send_request(OP_RESEND, 4'd6, 4'd0, '0);            // one hole left after this
    send_request(OP_RESEND, 4'd6, 4'd0, '0);
    send_request(OP_IGNORED, 4'd15, 4'd15, '1);         // unused opcode
    send_request(OP_WRITE_BITMAP, 4'd15, 4'd15, {32{2'b01}});
    send_request(OP_WRITE_BITMAP, 4'd9, 4'd0, {32{2'b10}});
    send_request(OP_RESEND, 4'd15, 4'd15, '0);
    send_request(OP_RESEND, 4'd9, 4'd0, '0);
    send_request(OP_QUEUE_WINDOW, 4'd15, 4'd0, '0);
    send_request(OP_QUEUE_WINDOW, 4'd0, 4'd15, '1);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // give every bitmap slot a value so no step ever reads an unwritten one
    for (int w = 0; w < BM_SLOTS; w++)
      send_request(OP_WRITE_BITMAP, WINDOW_W'(w), WINDOW_W'($urandom), rand_bitmap());
    run_directed();

    for (int p = 0; counted_items < ITEM_TARGET; p++) begin
      wait_drained();
      quiet = (p % 4 == 1);
      if (p < N_FIXED)
        apply_config(fixed_cfg[p][0], fixed_cfg[p][1], fixed_cfg[p][2],
                     fixed_cfg[p][3], fixed_cfg[p][4], fixed_cfg[p][5]);
      else
        apply_random_config();
      run_phase(PHASE_ITEMS);
    end

    wait_drained();
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
